/* sv/kfsi_pkg.sv */
package kfsi_pkg;

   // field widths
   localparam int TIME_W      = 32;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 8;
   localparam int SLOT_W      = 8;
   localparam int FRAC_W      = 16;
   localparam int DIFF_W      = TIME_W + 1;
   localparam int KEY_COUNT_W = 9;

   // table size default
   localparam int MAX_KEYS_DEFAULT = 256;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = KEY_COUNT_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_MODE = 2'd1;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_START,
      ST_FWD,
      ST_BWD,
      ST_DIFF,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_BLEND_GO,
      ST_BLEND_WAIT,
      ST_OUT
   } kfsi_state_type;

   // divider states
   typedef enum logic [1:0] {
      DV_IDLE,
      DV_CHECK,
      DV_RUN
   } kfsi_div_state_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] frac;
   } kfsi_div_result_type;

   // blend status toward the sequencer
   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] value;
   } kfsi_blend_result_type;

endpackage

/* sv/kfsi_key_mem.sv */
module kfsi_key_mem #(
   parameter int MAX_KEYS = kfsi_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [$clog2(MAX_KEYS)-1:0]                  wr_addr,
   input  logic [kfsi_pkg::TIME_W+kfsi_pkg::VALUE_W-1:0] wr_data,
   input  logic                                         rd_en,
   input  logic [$clog2(MAX_KEYS)-1:0]                  rd_addr,
   output logic [kfsi_pkg::TIME_W+kfsi_pkg::VALUE_W-1:0] rd_data
);

   localparam int DATA_W = kfsi_pkg::TIME_W + kfsi_pkg::VALUE_W;

   logic [DATA_W-1:0] mem [MAX_KEYS];
   logic [DATA_W-1:0] rd_data_ff;

   // key table write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/kfsi_frac_div.sv */
module kfsi_frac_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [kfsi_pkg::DIFF_W-1:0]  num,
   input  logic signed [kfsi_pkg::DIFF_W-1:0]  den,
   output kfsi_pkg::kfsi_div_result_type       result
);

   localparam int DW    = kfsi_pkg::DIFF_W;
   localparam int RW    = DW + 1;
   localparam int FW    = kfsi_pkg::FRAC_W;
   localparam int CNT_W = $clog2(FW);

   kfsi_pkg::kfsi_div_state_type state_ff, state_in;
   logic [DW-1:0]    nmag_ff, nmag_in;
   logic [DW-1:0]    dmag_ff, dmag_in;
   logic             zero_ff, zero_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [FW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [RW-1:0]    rem2_w;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kfsi_pkg::DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      zero_ff <= zero_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

   // restoring division, one quotient bit a cycle
   always_comb begin
      state_in = state_ff;
      nmag_in  = nmag_ff;
      dmag_in  = dmag_ff;
      zero_in  = zero_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      rem2_w   = {rem_ff[RW-2:0], 1'b0};
      case (state_ff)
         kfsi_pkg::DV_IDLE: begin
            if (start) begin
               nmag_in  = num[DW-1] ? DW'(-num) : DW'(num);
               dmag_in  = den[DW-1] ? DW'(-den) : DW'(den);
               zero_in  = (num == '0) || (den == '0) || (num[DW-1] != den[DW-1]);
               state_in = kfsi_pkg::DV_CHECK;
            end
         end
         kfsi_pkg::DV_CHECK: begin
            if (zero_ff) begin
               // opposite signs or a zero difference give no fraction
               quo_in   = '0;
               done_in  = 1'b1;
               state_in = kfsi_pkg::DV_IDLE;
            end else if (nmag_ff >= dmag_ff) begin
               // quotient would reach one: saturate
               quo_in   = '1;
               done_in  = 1'b1;
               state_in = kfsi_pkg::DV_IDLE;
            end else begin
               rem_in   = {1'b0, nmag_ff};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = kfsi_pkg::DV_RUN;
            end
         end
         kfsi_pkg::DV_RUN: begin
            if (rem2_w >= {1'b0, dmag_ff}) begin
               rem_in = rem2_w - {1'b0, dmag_ff};
               quo_in = {quo_ff[FW-2:0], 1'b1};
            end else begin
               rem_in = rem2_w;
               quo_in = {quo_ff[FW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FW - 1)) begin
               done_in  = 1'b1;
               state_in = kfsi_pkg::DV_IDLE;
            end
         end
         default: begin
            state_in = kfsi_pkg::DV_IDLE;
         end
      endcase
   end

   assign result.done = done_ff;
   assign result.frac = quo_ff;

endmodule

/* sv/kfsi_blend.sv */
module kfsi_blend (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 step_mode,
   input  logic signed [kfsi_pkg::VALUE_W-1:0]  value_a,
   input  logic signed [kfsi_pkg::VALUE_W-1:0]  value_b,
   input  logic [kfsi_pkg::FRAC_W-1:0]          frac,
   output kfsi_pkg::kfsi_blend_result_type      result
);

   localparam int VW = kfsi_pkg::VALUE_W;
   localparam int FW = kfsi_pkg::FRAC_W;
   localparam int DW = VW + 1;
   localparam int PW = DW + FW + 1;

   logic                 v1_ff, v2_ff, done_ff;
   logic signed [DW-1:0] d_ff;
   logic signed [PW-1:0] prod_ff;
   logic [VW-1:0]        va1_ff, vb1_ff, va2_ff, vb2_ff;
   logic [FW-1:0]        frac1_ff;
   logic                 step1_ff, step2_ff, half2_ff;
   logic [VW-1:0]        value_ff;
   logic signed [PW-1:0] rnd_w;
   logic signed [PW-1:0] shf_w;
   logic [VW-1:0]        lin_w;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   // stage one: key value difference
   always_ff @(posedge clock) begin
      if (start) begin
         d_ff     <= {value_b[VW-1], value_b} - {value_a[VW-1], value_a};
         va1_ff   <= value_a;
         vb1_ff   <= value_b;
         frac1_ff <= frac;
         step1_ff <= step_mode;
      end
   end

   // stage two: difference times fraction
   always_ff @(posedge clock) begin
      if (v1_ff) begin
         prod_ff  <= d_ff * $signed({1'b0, frac1_ff});
         va2_ff   <= va1_ff;
         vb2_ff   <= vb1_ff;
         step2_ff <= step1_ff;
         half2_ff <= frac1_ff[FW-1];
      end
   end

   // round half up, then add to the start value
   assign rnd_w = prod_ff + PW'(32768);
   assign shf_w = rnd_w >>> FW;
   assign lin_w = va2_ff + shf_w[VW-1:0];

   // stage three: pick step or linear result
   always_ff @(posedge clock) begin
      if (v2_ff) begin
         if (step2_ff) begin
            value_ff <= half2_ff ? vb2_ff : va2_ff;
         end else begin
            value_ff <= lin_w;
         end
      end
   end

   assign result.done  = done_ff;
   assign result.value = value_ff;

endmodule

/* sv/keyframe_search_interpolator_top.sv */
// Keyframe search interpolator. Key items (kind 0) write one time/value pair into the key
// table; slots at or beyond MAX_KEYS are dropped. Query items (kind 1) answer with one
// result item. An empty table answers found = 0; a query at or below the first key time
// clamps to that key (one table read plus the three-stage blend), one at or above the last
// key time clamps to the last key, and one that lands on the remembered key answers with
// that key. Other queries walk from the index remembered from the previous query, one key
// per cycle through the key memory read port, then run a restoring divide for the fraction
// and the blend multiply; the divide loop is skipped when the fraction is zero or saturates.
// One item is worked at a time and the block is ready for the next in the same cycle that
// the result appears; a waiting result sits in the output register while the next item is
// accepted. key_count above MAX_KEYS acts as MAX_KEYS; keys must be written before a query
// can reach them.
module keyframe_search_interpolator_top #(
   parameter int MAX_KEYS = kfsi_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [kfsi_pkg::SLOT_W-1:0]           req_key_slot,
   input  logic signed [kfsi_pkg::TIME_W-1:0]    req_key_time,
   input  logic signed [kfsi_pkg::VALUE_W-1:0]   req_key_value,
   input  logic signed [kfsi_pkg::TIME_W-1:0]    req_query_time,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_found,
   output logic signed [kfsi_pkg::VALUE_W-1:0]   rsp_value,
   output logic [kfsi_pkg::INDEX_W-1:0]          rsp_first_index,
   output logic [kfsi_pkg::INDEX_W-1:0]          rsp_second_index,
   output logic [kfsi_pkg::FRAC_W-1:0]           rsp_fraction,
   // configuration port
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [kfsi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [kfsi_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int AW     = $clog2(MAX_KEYS);
   localparam int CW     = AW + 1;
   localparam int TW     = kfsi_pkg::TIME_W;
   localparam int VW     = kfsi_pkg::VALUE_W;
   localparam int IW     = kfsi_pkg::INDEX_W;
   localparam int FW     = kfsi_pkg::FRAC_W;
   localparam int DW     = kfsi_pkg::DIFF_W;
   localparam int KW     = kfsi_pkg::KEY_COUNT_W;
   localparam int DATA_W = TW + VW;

   kfsi_pkg::kfsi_state_type state_ff, state_in;

   logic [KW-1:0]        key_count_ff, key_count_in;
   logic                 step_mode_ff, step_mode_in;
   logic [IW-1:0]        last_index_ff, last_index_in;
   logic signed [TW-1:0] q_ff, q_in;
   logic [AW-1:0]        a_ff, a_in;
   logic [AW-1:0]        b_ff, b_in;
   logic signed [TW-1:0] ta_ff, ta_in;
   logic signed [TW-1:0] tb_ff, tb_in;
   logic [VW-1:0]        va_ff, va_in;
   logic [VW-1:0]        vb_ff, vb_in;
   logic signed [DW-1:0] num_ff, num_in;
   logic signed [DW-1:0] den_ff, den_in;
   logic [FW-1:0]        frac_ff, frac_in;
   logic                 found_ff, found_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [VW-1:0]        rsp_value_ff, rsp_value_in;
   logic [IW-1:0]        rsp_first_ff, rsp_first_in;
   logic [IW-1:0]        rsp_second_ff, rsp_second_in;
   logic [FW-1:0]        rsp_frac_ff, rsp_frac_in;

   logic                 req_accept_w;
   logic                 slot_ok_w;
   logic [CW-1:0]        n_w;
   logic [CW-1:0]        n_m1_w;
   logic [AW-1:0]        last_w;
   logic [AW-1:0]        start_w;
   logic                 wr_en_w;
   logic                 rd_en_w;
   logic [AW-1:0]        rd_addr_w;
   logic [DATA_W-1:0]    rd_data_w;
   logic signed [TW-1:0] rd_time_w;
   logic [VW-1:0]        rd_value_w;
   logic                 div_start_w;
   logic                 blend_start_w;

   kfsi_pkg::kfsi_div_result_type   div_res_w;
   kfsi_pkg::kfsi_blend_result_type blend_res_w;

   // key table
   kfsi_key_mem #(
      .MAX_KEYS (MAX_KEYS)
   ) u_key_mem (
      .clock   (clock),
      .wr_en   (wr_en_w),
      .wr_addr (AW'(req_key_slot)),
      .wr_data ({req_key_time, req_key_value}),
      .rd_en   (rd_en_w),
      .rd_addr (rd_addr_w),
      .rd_data (rd_data_w)
   );

   // fraction divider
   kfsi_frac_div u_frac_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start_w),
      .num    (num_ff),
      .den    (den_ff),
      .result (div_res_w)
   );

   // linear or step blend
   kfsi_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .start     (blend_start_w),
      .step_mode (step_mode_ff),
      .value_a   (va_ff),
      .value_b   (vb_ff),
      .frac      (frac_ff),
      .result    (blend_res_w)
   );

   // handshakes and table bounds
   assign csr_ready    = 1'b1;
   assign req_ready    = (state_ff == kfsi_pkg::ST_IDLE);
   assign req_accept_w = req_valid && req_ready;
   assign slot_ok_w    = (32'(req_key_slot) < MAX_KEYS);
   assign n_w          = (32'(key_count_ff) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count_ff);
   assign n_m1_w       = n_w - CW'(1);
   assign last_w       = n_m1_w[AW-1:0];
   assign start_w      = (32'(last_index_ff) < 32'(n_w)) ? AW'(last_index_ff) : '0;
   assign rd_time_w    = rd_data_w[DATA_W-1:VW];
   assign rd_value_w   = rd_data_w[VW-1:0];

   // configuration registers
   always_comb begin
      key_count_in = key_count_ff;
      step_mode_in = step_mode_ff;
      if (csr_valid) begin
         case (csr_index)
            kfsi_pkg::CSR_KEY_COUNT: key_count_in = csr_data[KW-1:0];
            kfsi_pkg::CSR_STEP_MODE: step_mode_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kfsi_pkg::ST_IDLE;
         key_count_ff  <= '0;
         step_mode_ff  <= 1'b0;
         last_index_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         key_count_ff  <= key_count_in;
         step_mode_ff  <= step_mode_in;
         last_index_ff <= last_index_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      q_ff          <= q_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      ta_ff         <= ta_in;
      tb_ff         <= tb_in;
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      frac_ff       <= frac_in;
      found_ff      <= found_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_frac_ff   <= rsp_frac_in;
   end

   // search sequencer
   always_comb begin
      state_in      = state_ff;
      last_index_in = last_index_ff;
      q_in          = q_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      ta_in         = ta_ff;
      tb_in         = tb_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      frac_in       = frac_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_frac_in   = rsp_frac_ff;
      wr_en_w       = 1'b0;
      rd_en_w       = 1'b0;
      rd_addr_w     = '0;
      div_start_w   = 1'b0;
      blend_start_w = 1'b0;
      case (state_ff)
         kfsi_pkg::ST_IDLE: begin
            if (req_accept_w) begin
               if (req_kind == kfsi_pkg::KIND_WRITE) begin
                  wr_en_w = slot_ok_w;
               end else begin
                  q_in    = req_query_time;
                  a_in    = '0;
                  b_in    = '0;
                  frac_in = '0;
                  if (n_w == '0) begin
                     found_in = 1'b0;
                     state_in = kfsi_pkg::ST_OUT;
                  end else begin
                     found_in  = 1'b1;
                     rd_en_w   = 1'b1;
                     rd_addr_w = '0;
                     state_in  = kfsi_pkg::ST_FIRST;
                  end
               end
            end
         end
         kfsi_pkg::ST_FIRST: begin
            // clamp below the first key
            if (q_ff <= rd_time_w) begin
               va_in    = rd_value_w;
               vb_in    = rd_value_w;
               state_in = kfsi_pkg::ST_BLEND_GO;
            end else begin
               rd_en_w   = 1'b1;
               rd_addr_w = last_w;
               state_in  = kfsi_pkg::ST_LAST;
            end
         end
         kfsi_pkg::ST_LAST: begin
            // clamp above the last key
            if (q_ff >= rd_time_w) begin
               a_in     = last_w;
               b_in     = last_w;
               va_in    = rd_value_w;
               vb_in    = rd_value_w;
               state_in = kfsi_pkg::ST_BLEND_GO;
            end else begin
               a_in      = start_w;
               rd_en_w   = 1'b1;
               rd_addr_w = start_w;
               state_in  = kfsi_pkg::ST_START;
            end
         end
         kfsi_pkg::ST_START: begin
            ta_in = rd_time_w;
            va_in = rd_value_w;
            if (q_ff > rd_time_w) begin
               b_in      = (a_ff < last_w) ? a_ff + AW'(1) : last_w;
               rd_en_w   = 1'b1;
               rd_addr_w = b_in;
               state_in  = kfsi_pkg::ST_FWD;
            end else if (q_ff < rd_time_w) begin
               b_in      = (a_ff != '0) ? a_ff - AW'(1) : '0;
               rd_en_w   = 1'b1;
               rd_addr_w = b_in;
               state_in  = kfsi_pkg::ST_BWD;
            end else begin
               // exact hit on the remembered key
               b_in     = a_ff;
               vb_in    = rd_value_w;
               state_in = kfsi_pkg::ST_BLEND_GO;
            end
         end
         kfsi_pkg::ST_FWD: begin
            // forward walk, stops at the last key
            if ((b_ff < last_w) && (q_ff >= rd_time_w)) begin
               a_in      = b_ff;
               ta_in     = rd_time_w;
               va_in     = rd_value_w;
               b_in      = b_ff + AW'(1);
               rd_en_w   = 1'b1;
               rd_addr_w = b_in;
            end else begin
               tb_in    = rd_time_w;
               vb_in    = rd_value_w;
               state_in = kfsi_pkg::ST_DIFF;
            end
         end
         kfsi_pkg::ST_BWD: begin
            // backward walk, stops at key zero
            if ((b_ff != '0) && (q_ff <= rd_time_w)) begin
               a_in      = b_ff;
               ta_in     = rd_time_w;
               va_in     = rd_value_w;
               b_in      = b_ff - AW'(1);
               rd_en_w   = 1'b1;
               rd_addr_w = b_in;
            end else begin
               tb_in    = rd_time_w;
               vb_in    = rd_value_w;
               state_in = kfsi_pkg::ST_DIFF;
            end
         end
         kfsi_pkg::ST_DIFF: begin
            num_in   = {q_ff[TW-1], q_ff} - {ta_ff[TW-1], ta_ff};
            den_in   = {tb_ff[TW-1], tb_ff} - {ta_ff[TW-1], ta_ff};
            state_in = kfsi_pkg::ST_DIV_GO;
         end
         kfsi_pkg::ST_DIV_GO: begin
            div_start_w = 1'b1;
            state_in    = kfsi_pkg::ST_DIV_WAIT;
         end
         kfsi_pkg::ST_DIV_WAIT: begin
            if (div_res_w.done) begin
               frac_in  = div_res_w.frac;
               state_in = kfsi_pkg::ST_BLEND_GO;
            end
         end
         kfsi_pkg::ST_BLEND_GO: begin
            blend_start_w = 1'b1;
            state_in      = kfsi_pkg::ST_BLEND_WAIT;
         end
         kfsi_pkg::ST_BLEND_WAIT: begin
            if (blend_res_w.done) begin
               state_in = kfsi_pkg::ST_OUT;
            end
         end
         kfsi_pkg::ST_OUT: begin
            // hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_value_in  = found_ff ? blend_res_w.value : '0;
               rsp_first_in  = IW'(a_ff);
               rsp_second_in = IW'(b_ff);
               rsp_frac_in   = frac_ff;
               if (found_ff) begin
                  last_index_in = IW'(a_ff);
               end
               state_in = kfsi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kfsi_pkg::ST_IDLE;
         end
      endcase
   end

   // result outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_first_index  = rsp_first_ff;
   assign rsp_second_index = rsp_second_ff;
   assign rsp_fraction     = rsp_frac_ff;

endmodule

/* test/tb_keyframe_search_interpolator_top.sv */
module tb_keyframe_search_interpolator_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIME_W      = kfsi_pkg::TIME_W;
   localparam int VALUE_W     = kfsi_pkg::VALUE_W;
   localparam int INDEX_W     = kfsi_pkg::INDEX_W;
   localparam int SLOT_W      = kfsi_pkg::SLOT_W;
   localparam int FRAC_W      = kfsi_pkg::FRAC_W;
   localparam int KEY_COUNT_W = kfsi_pkg::KEY_COUNT_W;
   localparam int CSR_INDEX_W = kfsi_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = kfsi_pkg::CSR_DATA_W;

   localparam int TABLE_DEPTH    = kfsi_pkg::MAX_KEYS_DEFAULT;
   localparam int TIME_MIN       = 32'sh8000_0000;
   localparam int TIME_MAX       = 32'sh7fff_ffff;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 1000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd2;

   typedef enum int {SHAPE_RISING, SHAPE_REPEATS, SHAPE_SCRAMBLED} table_shape_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] second_index;
      logic [FRAC_W-1:0]  fraction;
   } answer_type;

   // key table mirror, search state and the answers still owed by the block
   class interp_board_type;
      int                     key_time [TABLE_DEPTH];
      int                     key_value [TABLE_DEPTH];
      logic [INDEX_W-1:0]     last_index = '0;
      logic [KEY_COUNT_W-1:0] key_count = '0;
      logic                   step_mode = 1'b0;
      answer_type             awaited [$];
      int                     failures = 0;

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == kfsi_pkg::CSR_KEY_COUNT)
            key_count = data;
         else if (idx == kfsi_pkg::CSR_STEP_MODE)
            step_mode = data[0];
      endfunction

      // q0.16 position of num within den, zero on opposite signs, saturating
      function longint span_fraction(longint num, longint den);
         longint unsigned un, ud, quo;
         if (den == 0 || num == 0)
            return 0;
         if ((num < 0) != (den < 0))
            return 0;
         un = (num < 0) ? -num : num;
         ud = (den < 0) ? -den : den;
         quo = (un << 16) / ud;
         return (quo > 65535) ? 65535 : quo;
      endfunction

      function void take_item(logic kind, logic [SLOT_W-1:0] slot, int ktime, int kvalue,
                              int qtime);
         answer_type ans;
         int         n, a, b;
         longint     q, frac, val, d;
         if (kind == kfsi_pkg::KIND_WRITE) begin
            key_time[slot] = ktime;
            key_value[slot] = kvalue;
            return;
         end
         ans = '0;
         frac = 0;
         n = (int'(key_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(key_count);
         // empty table leaves the remembered index alone
         if (n == 0) begin
            awaited.push_back(ans);
            return;
         end
         q = longint'(qtime);
         if (q <= longint'(key_time[0])) begin
            a = 0;
            b = 0;
         end else if (q >= longint'(key_time[n-1])) begin
            a = n - 1;
            b = n - 1;
         end else begin
            a = (int'(last_index) < n) ? int'(last_index) : 0;
            if (q > longint'(key_time[a])) begin
               // walk forward, never past the last key
               b = (a + 1 < n) ? a + 1 : n - 1;
               while (b < n - 1 && q >= longint'(key_time[b])) begin
                  a = b;
                  b++;
               end
               frac = span_fraction(q - longint'(key_time[a]),
                                    longint'(key_time[b]) - longint'(key_time[a]));
            end else if (q < longint'(key_time[a])) begin
               // walk backward, never below key zero
               b = (a > 0) ? a - 1 : 0;
               while (b > 0 && q <= longint'(key_time[b])) begin
                  a = b;
                  b--;
               end
               frac = span_fraction(q - longint'(key_time[a]),
                                    longint'(key_time[b]) - longint'(key_time[a]));
            end else begin
               b = a;
            end
         end
         // step choice or blend rounded half up
         if (step_mode)
            val = (frac < 32768) ? longint'(key_value[a]) : longint'(key_value[b]);
         else begin
            d = longint'(key_value[b]) - longint'(key_value[a]);
            val = longint'(key_value[a]) + ((d * frac + 32768) >>> 16);
         end
         last_index = a[INDEX_W-1:0];
         ans.found = 1'b1;
         ans.value = val[VALUE_W-1:0];
         ans.first_index = a[INDEX_W-1:0];
         ans.second_index = b[INDEX_W-1:0];
         ans.fraction = frac[FRAC_W-1:0];
         awaited.push_back(ans);
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("result item with no query pending: found=%0b value=%0d",
                        got.found, $signed(got.value));
            return;
         end
         want = awaited.pop_front();
         if (got.found !== want.found || got.value !== want.value ||
             got.first_index !== want.first_index || got.second_index !== want.second_index ||
             got.fraction !== want.fraction) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch: expected found=%0b value=%0d first=%0d second=%0d frac=%0d",
                        want.found, $signed(want.value), want.first_index,
                        want.second_index, want.fraction);
               $display("          actual   found=%0b value=%0d first=%0d second=%0d frac=%0d",
                        got.found, $signed(got.value), got.first_index,
                        got.second_index, got.fraction);
            end
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_kind = kfsi_pkg::KIND_WRITE;
   logic [SLOT_W-1:0]         req_key_slot = '0;
   logic signed [TIME_W-1:0]  req_key_time = '0;
   logic signed [VALUE_W-1:0] req_key_value = '0;
   logic signed [TIME_W-1:0]  req_query_time = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_found;
   logic signed [VALUE_W-1:0] rsp_value;
   logic [INDEX_W-1:0]        rsp_first_index;
   logic [INDEX_W-1:0]        rsp_second_index;
   logic [FRAC_W-1:0]         rsp_fraction;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   interp_board_type sb;
   bit               req_up = 1'b0;
   bit               calm = 1'b0;
   int               sent_items = 0;
   int               anim_cursor = 0;
   int               quiet_cycles = 0;

   keyframe_search_interpolator_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_key_slot    (req_key_slot),
      .req_key_time    (req_key_time),
      .req_key_value   (req_key_value),
      .req_query_time  (req_query_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_value       (rsp_value),
      .rsp_first_index (rsp_first_index),
      .rsp_second_index(rsp_second_index),
      .rsp_fraction    (rsp_fraction),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // check every result item and watch for a stuck handshake
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_answer('{rsp_found, rsp_value, rsp_first_index, rsp_second_index,
                           rsp_fraction});
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: random stall before taking each item
   initial begin
      int unsigned hold;
      while (reset) @(posedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 8);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // one input item, valid held until accepted
   task automatic send_item(logic kind, int slot, int ktime, int kvalue, int qtime);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         if (req_up)
            req_valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_key_slot <= slot[SLOT_W-1:0];
      req_key_time <= ktime;
      req_key_value <= kvalue;
      req_query_time <= qtime;
      req_up = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.take_item(kind, slot[SLOT_W-1:0], ktime, kvalue, qtime);
      sent_items++;
   endtask

   task automatic release_req();
      if (req_up)
         req_valid <= 1'b0;
      req_up = 1'b0;
   endtask

   task automatic drain_results();
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(idx, data);
   endtask

   // registers change only once the block has gone quiet
   task automatic configure(int count, int step_data);
      release_req();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(kfsi_pkg::CSR_KEY_COUNT, count[CSR_DATA_W-1:0]);
      csr_write(kfsi_pkg::CSR_STEP_MODE, step_data[CSR_DATA_W-1:0]);
      csr_valid <= 1'b0;
   endtask

   // fill slots 0..count-1 with rising, repeating or scrambled key times
   task automatic load_table(int count, table_shape_type shape);
      longint cap, t, tk, span;
      int     k;
      case ($urandom_range(0, 5))
         0: cap = 1;
         1: cap = 16;
         2: cap = 65536;
         3: cap = 1 << 20;
         4: cap = 1 << 24;
         default: cap = 1 << 28;
      endcase
      if (cap * longint'(count) > 64'sd2147483648)
         cap = 64'sd2147483648 / longint'(count);
      span = cap * longint'(count);
      t = longint'(TIME_MIN) + longint'($urandom_range(0, 32'(64'sd4294967295 - span)));
      for (k = 0; k < count; k++) begin
         if (shape == SHAPE_SCRAMBLED)
            tk = longint'(int'($urandom));
         else begin
            tk = t;
            if (!(shape == SHAPE_REPEATS && $urandom_range(0, 2) == 0))
               t = t + longint'($urandom_range(1, 32'(cap)));
         end
         send_item(kfsi_pkg::KIND_WRITE, k, int'(tk), $urandom, $urandom);
      end
   endtask

   // query times cluster around a slowly moving key, like playback
   function automatic int pick_query_time(int n);
      int     r, i;
      longint lo, hi, t;
      r = $urandom_range(0, 99);
      if (n == 0 || r < 8)
         return $urandom;
      if (r < 12)
         return ($urandom_range(0, 1) != 0) ? TIME_MAX : TIME_MIN;
      if ($urandom_range(0, 9) == 0)
         anim_cursor = $urandom_range(0, n - 1);
      else
         anim_cursor = anim_cursor + int'($urandom_range(0, 4)) - 2;
      if (anim_cursor < 0)
         anim_cursor = 0;
      if (anim_cursor > n - 1)
         anim_cursor = n - 1;
      i = anim_cursor;
      lo = longint'(sb.key_time[i]);
      if (r < 20)
         t = longint'(sb.key_time[0]) - longint'($urandom_range(0, 65536));
      else if (r < 28)
         t = longint'(sb.key_time[n-1]) + longint'($urandom_range(0, 65536));
      else if (r < 50 || i == n - 1)
         t = lo;
      else begin
         hi = longint'(sb.key_time[i+1]);
         t = lo + (((hi - lo) * longint'($urandom_range(0, 65535))) >>> 16);
      end
      if (t < longint'(TIME_MIN))
         t = longint'(TIME_MIN);
      if (t > longint'(TIME_MAX))
         t = longint'(TIME_MAX);
      return int'(t);
   endfunction

   initial begin
      int              lin_points [9] = '{TIME_MIN, TIME_MAX, 0, -65536, 327680, 131072,
                                          -1073741824, 2147483646, 1};
      int              step_points [3] = '{131072, 131071, -1073741824};
      int              base, n_cfg, n_eff, n_q, pause_at, j, r, phase;
      table_shape_type shape;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // unused register index, then explicit reset values
      csr_write(CSR_SPARE, 9'h1ff);
      csr_write(kfsi_pkg::CSR_KEY_COUNT, 9'd0);
      csr_write(kfsi_pkg::CSR_STEP_MODE, 9'd0);
      csr_valid <= 1'b0;

      // empty table answers not found
      send_item(kfsi_pkg::KIND_QUERY, 255, TIME_MAX, TIME_MIN, TIME_MIN);
      send_item(kfsi_pkg::KIND_QUERY, 0, 0, 0, TIME_MAX);

      // four keys spanning the whole time range, extreme values
      send_item(kfsi_pkg::KIND_WRITE, 0, TIME_MIN, TIME_MAX, $urandom);
      send_item(kfsi_pkg::KIND_WRITE, 1, -65536, TIME_MIN, $urandom);
      send_item(kfsi_pkg::KIND_WRITE, 2, 327680, 0, $urandom);
      send_item(kfsi_pkg::KIND_WRITE, 3, TIME_MAX, 12345, $urandom);
      configure(4, 0);
      // clamps, exact keys, walks both ways, exact half point
      foreach (lin_points[k])
         send_item(kfsi_pkg::KIND_QUERY, $urandom, $urandom, $urandom, lin_points[k]);
      // step mode around the half point, upper data bits ignored
      configure(4, 511);
      foreach (step_points[k])
         send_item(kfsi_pkg::KIND_QUERY, $urandom, $urandom, $urandom, step_points[k]);
      configure(4, 2);
      // out of order key: fraction with opposite signs
      send_item(kfsi_pkg::KIND_WRITE, 2, -200000, 0, $urandom);
      send_item(kfsi_pkg::KIND_QUERY, $urandom, $urandom, $urandom, -100000);
      send_item(kfsi_pkg::KIND_QUERY, $urandom, $urandom, $urandom, 100000);
      send_item(kfsi_pkg::KIND_WRITE, 2, 327680, 0, $urandom);

      // whole table written once so any count reads only written keys
      load_table(TABLE_DEPTH, SHAPE_RISING);
      configure(511, 0);
      repeat (10)
         send_item(kfsi_pkg::KIND_QUERY, $urandom, $urandom, $urandom,
                   pick_query_time(TABLE_DEPTH));

      // random phases: new count and mode, usually a fresh table, then queries
      base = sent_items;
      phase = 0;
      while (sent_items < base + RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 5)
            n_cfg = 0;
         else if (r < 15)
            n_cfg = 1;
         else if (r < 65)
            n_cfg = $urandom_range(2, 16);
         else if (r < 80)
            n_cfg = $urandom_range(17, 64);
         else if (r < 90)
            n_cfg = TABLE_DEPTH;
         else
            n_cfg = $urandom_range(TABLE_DEPTH + 1, 511);
         n_eff = (n_cfg > TABLE_DEPTH) ? TABLE_DEPTH : n_cfg;
         r = $urandom_range(0, 99);
         shape = (r < 70) ? SHAPE_RISING : (r < 85) ? SHAPE_REPEATS : SHAPE_SCRAMBLED;
         calm = ($urandom_range(0, 3) == 0);
         configure(n_cfg, $urandom_range(0, 511));
         if (n_eff != 0 && (n_eff <= 64 || $urandom_range(0, 3) == 0))
            load_table(n_eff, shape);
         n_q = $urandom_range(20, 60);
         pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(1, n_q - 1) : -1;
         for (j = 0; j < n_q; j++) begin
            // sender holds off until every answer is in
            if (j == pause_at) begin
               release_req();
               drain_results();
            end
            if ($urandom_range(0, 9) == 0)
               send_item(kfsi_pkg::KIND_WRITE, $urandom, $urandom, $urandom, $urandom);
            else
               send_item(kfsi_pkg::KIND_QUERY, $urandom, $urandom, $urandom,
                         pick_query_time(n_eff));
         end
         phase++;
      end

      release_req();
      calm = 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.awaited.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
